FILE: rtl/bracket_interpolate_square_root_defines.svh
// ----------------------------------------------------------------------------
// bracket interpolate square root: assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef BRACKET_INTERPOLATE_SQUARE_ROOT_DEFINES_SVH
`define BRACKET_INTERPOLATE_SQUARE_ROOT_DEFINES_SVH

// condition a implies condition b in the same cycle
`define BISR_ASSERT_SAME(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// condition a implies condition b in the next cycle
`define BISR_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

FILE: rtl/bisr_pkg.sv
// ----------------------------------------------------------------------------
// bisr_pkg
// datapath commands and status shared by controller and datapath
// ----------------------------------------------------------------------------
`default_nettype none

package bisr_pkg;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_BRACKET,
    OP_LSQ,
    OP_DIV1_START,
    OP_RES,
    OP_SQUARE,
    OP_DIV2_START,
    OP_CMUL,
    OP_FINAL,
    OP_BYPASS
  } op_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_busy;
    logic need_corr;
    logic q_ge_three;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/bisr_divider.sv
// ----------------------------------------------------------------------------
// bisr_divider
// restoring divider, one quotient bit per cycle, shared by both divisions
// ----------------------------------------------------------------------------
`default_nettype none

module bisr_divider #(
  parameter int NW = 68,
  parameter int DW = 48,
  parameter int CW = $clog2(NW + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] rem0,
  input  wire logic [NW-1:0] numer,
  input  wire logic [CW-1:0] steps,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic [NW-1:0]      quot
);

  logic [DW-1:0] rem;
  logic [NW-1:0] nsr;
  logic [DW-1:0] dreg;
  logic [CW-1:0] cnt;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    shifted = {rem, nsr[NW-1]};
    ge      = shifted >= {1'b0, dreg};
    diff    = shifted - {1'b0, dreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= steps;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= rem0;
      nsr  <= numer;
      dreg <= den;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      nsr  <= {nsr[NW-2:0], 1'b0};
      quot <= {quot[NW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bisr_datapath.sv
// ----------------------------------------------------------------------------
// bisr_datapath
// magnitude, digit square root, bracket, interpolation and correction
// ----------------------------------------------------------------------------
`default_nettype none

module bisr_datapath #(
  parameter int FRAC_BITS = 16,
  parameter int INT_BITS  = 32,
  localparam int W   = INT_BITS + FRAC_BITS,
  localparam int OUT = (INT_BITS + 1) / 2 + FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bisr_pkg::op_t      op,
  input  wire logic [W-1:0]       value,
  output bisr_pkg::dp_status_t    status,
  output logic [OUT-1:0]          root
);

  localparam int F  = FRAC_BITS;
  localparam int SW = (INT_BITS + 1) / 2 + 1;
  localparam int XW = 2 * SW;
  localparam int RB = SW + F + 1;
  localparam int NW = 2 * RB;
  localparam int LW = 2 * SW + F;
  localparam int PW = RB + F + 2;
  localparam int CW = $clog2(NW + 1);
  localparam int SC = $clog2(SW + 1);

  logic [W-1:0]    mag;
  logic [XW-1:0]   x;
  logic [SW:0]     srem;
  logic [SW-1:0]   sroot;
  logic [SC-1:0]   scnt;
  logic [SW-1:0]   u;
  logic [SW-1:0]   l;
  logic [2*SW-1:0] lsq;
  logic [RB-1:0]   res;
  logic [NW-1:0]   sq;
  logic [PW-1:0]   prod;

  logic [INT_BITS:0] r;
  logic [SW+2:0]     cur;
  logic [SW+2:0]     trial;
  logic              sge;
  logic [SW-1:0]     u_next;
  logic [LW-1:0]     lsqs;
  logic [LW-1:0]     mag_ext;
  logic [LW-1:0]     dsub;
  logic [NW-1:0]     three;
  logic [F+1:0]      factor;
  logic [RB:0]       shd;

  logic          div_start;
  logic [W-1:0]  div_rem0;
  logic [NW-1:0] div_numer;
  logic [CW-1:0] div_steps;
  logic [W-1:0]  div_den;
  logic          div_busy;
  logic [NW-1:0] quot;

  always_comb begin
    r       = (INT_BITS + 1)'(mag[W-1:F]) + (INT_BITS + 1)'(mag[F-1]);
    cur     = {srem, x[XW-1:XW-2]};
    trial   = (SW + 3)'({sroot, 2'b01});
    sge     = cur >= trial;
    u_next  = (srem == '0) ? sroot : sroot + 1'b1;
    if (u_next == '0) begin
      u_next = SW'(1);
    end
    lsqs    = {lsq, {F{1'b0}}};
    mag_ext = LW'(mag);
    dsub    = (mag_ext > lsqs) ? mag_ext - lsqs : '0;
    three   = NW'(3) << F;
    factor  = three[F+1:0] - quot[F+1:0];
    shd     = prod[PW-1:F+1];
  end

  always_comb begin
    div_start = 1'b0;
    div_rem0  = '0;
    div_numer = '0;
    div_steps = '0;
    div_den   = mag;
    unique case (op)
      bisr_pkg::OP_DIV1_START: begin
        div_start = 1'b1;
        div_rem0  = W'(dsub[W-1:F+1]);
        div_numer = {dsub[F:0], {(NW - F - 1){1'b0}}};
        div_steps = CW'(F + 1);
        div_den   = W'({u, 1'b0} - 1'b1);
      end
      bisr_pkg::OP_DIV2_START: begin
        div_start = 1'b1;
        div_numer = sq;
        div_steps = CW'(NW);
      end
      default: begin
      end
    endcase
  end

  bisr_divider #(
    .NW (NW),
    .DW (W),
    .CW (CW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .rem0  (div_rem0),
    .numer (div_numer),
    .steps (div_steps),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (quot)
  );

  always_comb begin
    status.sqrt_done  = scnt == '0;
    status.div_busy   = div_busy;
    status.need_corr  = (res[F-1:0] != '0) && (mag != '0);
    status.q_ge_three = quot >= three;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scnt <= '0;
    end else if (op == bisr_pkg::OP_SQRT_INIT) begin
      scnt <= SC'(SW);
    end else if (op == bisr_pkg::OP_SQRT_STEP) begin
      scnt <= scnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      bisr_pkg::OP_LOAD: begin
        mag <= value[W-1] ? W'(-value) : value;
      end
      bisr_pkg::OP_SQRT_INIT: begin
        x     <= XW'(r);
        srem  <= '0;
        sroot <= '0;
      end
      bisr_pkg::OP_SQRT_STEP: begin
        x     <= {x[XW-3:0], 2'b00};
        srem  <= sge ? (SW + 1)'(cur - trial) : (SW + 1)'(cur);
        sroot <= {sroot[SW-2:0], sge};
      end
      bisr_pkg::OP_BRACKET: begin
        u <= u_next;
        l <= u_next - 1'b1;
      end
      bisr_pkg::OP_LSQ: begin
        lsq <= l * l;
      end
      bisr_pkg::OP_RES: begin
        res <= RB'({l, {F{1'b0}}}) + RB'(quot[F:0]);
      end
      bisr_pkg::OP_SQUARE: begin
        sq <= res * res;
      end
      bisr_pkg::OP_CMUL: begin
        prod <= res * factor;
      end
      bisr_pkg::OP_FINAL: begin
        if (status.q_ge_three) begin
          root <= '0;
        end else if (shd[RB:OUT] != '0) begin
          root <= '1;
        end else begin
          root <= shd[OUT-1:0];
        end
      end
      bisr_pkg::OP_BYPASS: begin
        root <= (res[RB-1:OUT] != '0) ? '1 : res[OUT-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/bisr_ctrl.sv
// ----------------------------------------------------------------------------
// bisr_ctrl
// sequencer for one item at a time and output valid register
// ----------------------------------------------------------------------------
`default_nettype none

`include "bracket_interpolate_square_root_defines.svh"

module bisr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire bisr_pkg::dp_status_t status,
  output bisr_pkg::op_t             op
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQI, S_SQ, S_BRK, S_LSQ, S_D1S, S_D1W, S_RES,
    S_CHK, S_BYP, S_SQR, S_D2S, S_D2W, S_CMUL, S_FIN
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = state == S_IDLE;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    op = bisr_pkg::OP_NONE;
    unique case (state)
      S_IDLE:  if (in_valid) op = bisr_pkg::OP_LOAD;
      S_SQI:   op = bisr_pkg::OP_SQRT_INIT;
      S_SQ:    if (!status.sqrt_done) op = bisr_pkg::OP_SQRT_STEP;
      S_BRK:   op = bisr_pkg::OP_BRACKET;
      S_LSQ:   op = bisr_pkg::OP_LSQ;
      S_D1S:   op = bisr_pkg::OP_DIV1_START;
      S_RES:   op = bisr_pkg::OP_RES;
      S_BYP:   if (out_free) op = bisr_pkg::OP_BYPASS;
      S_SQR:   op = bisr_pkg::OP_SQUARE;
      S_D2S:   op = bisr_pkg::OP_DIV2_START;
      S_CMUL:  op = bisr_pkg::OP_CMUL;
      S_FIN:   if (out_free) op = bisr_pkg::OP_FINAL;
      default: op = bisr_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_BYP || state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_SQI;
        S_SQI:   state <= S_SQ;
        S_SQ:    if (status.sqrt_done) state <= S_BRK;
        S_BRK:   state <= S_LSQ;
        S_LSQ:   state <= S_D1S;
        S_D1S:   state <= S_D1W;
        S_D1W:   if (!status.div_busy) state <= S_RES;
        S_RES:   state <= S_CHK;
        S_CHK:   state <= status.need_corr ? S_SQR : S_BYP;
        S_SQR:   state <= S_D2S;
        S_D2S:   state <= S_D2W;
        S_D2W:   if (!status.div_busy) state <= S_CMUL;
        S_CMUL:  state <= S_FIN;
        S_BYP, S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BISR_ASSERT_SAME(a_idle_div_free, state == S_IDLE, !status.div_busy)
  `BISR_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == S_SQI)
  `BISR_ASSERT_NEXT(a_finish_valid, (state == S_FIN || state == S_BYP) && out_free, out_valid)

endmodule

`default_nettype wire

FILE: rtl/bracket_interpolate_square_root.sv
// ----------------------------------------------------------------------------
// bracket_interpolate_square_root
// approximate square root of a signed fixed-point operand's magnitude
// ----------------------------------------------------------------------------
// latency at defaults: 17 root digit steps and 17 divider steps, plus 68 more
//   divider steps with correction; one item at a time, taken only when idle,
//   and an item cannot finish while m_tready stalls a full output register;
//   the shared one-bit-per-cycle divider and the root digit loop set the pace
// a finished result waits in the output register while the next item runs
// reset: synchronous active-high rst clears controller and valid state
`default_nettype none

module bracket_interpolate_square_root #(
  parameter int FRAC_BITS = 16,
  parameter int INT_BITS  = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  // input stream
  input  wire logic s_tvalid,
  output logic      s_tready,
  // fields from bit 0: value (INT_BITS + FRAC_BITS, signed)
  input  wire logic [((INT_BITS + FRAC_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // output stream
  output logic      m_tvalid,
  input  wire logic m_tready,
  // fields from bit 0: root (unsigned, saturated)
  output logic [(((INT_BITS + 1) / 2 + FRAC_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int W   = INT_BITS + FRAC_BITS;
  localparam int OUT = (INT_BITS + 1) / 2 + FRAC_BITS;
  localparam int OBW = ((OUT + 7) / 8) * 8;

  bisr_pkg::op_t      op;
  bisr_pkg::dp_status_t status;
  logic [OUT-1:0]     root;

  // sequencer: magnitude, root digits, bracket, interpolation, correction
  bisr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .op        (op)
  );

  // arithmetic, holding the result register behind m_tdata
  bisr_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .INT_BITS  (INT_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .value  (s_tdata[W-1:0]),
    .status (status),
    .root   (root)
  );

  // zero padding up to whole bytes
  assign m_tdata = OBW'(root);

endmodule

`default_nettype wire
